/* design/lpbp_pkg.sv */
package lpbp_pkg;

  localparam int POOL_ENTRIES_DEF = 32;
  localparam int FILE_ID_BITS_DEF = 8;
  localparam int PAGE_BITS_DEF    = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [5:0] POOL_LIMIT_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_FETCH     = 2'd0,
    OP_FLUSH     = 2'd1,
    OP_FLUSH_ALL = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  file_id;
    logic [31:0] page_number;
    logic        mark_dirty;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  slot;
    logic        load_needed;
    logic        writeback_needed;
    logic [7:0]  writeback_file;
    logic [31:0] writeback_page;
    logic        last;
  } out_item_t;

endpackage

/* design/lpbp_front.sv */
// Front end: accepts beats, drops the unused opcode, and queues commands.
module lpbp_front #(
  parameter int QDEPTH = lpbp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpbp_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_take,
  output lpbp_pkg::in_item_t cmd_data
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  lpbp_pkg::in_item_t q_r [QDEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;
  logic          acc, push;

  assign in_stall  = (cnt_r == (AW+1)'(QDEPTH));
  assign acc       = in_valid && !in_stall;
  // opcode 3 gives no result, so it is accepted and dropped here
  assign push      = acc && (in_data.opcode != lpbp_pkg::OP_NONE);
  assign cmd_valid = (cnt_r != '0);
  assign cmd_data  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= in_data;
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(QDEPTH-1)) ? '0 : wr_r + 1'b1;
      if (cmd_take) rd_r <= (rd_r == AW'(QDEPTH-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(cmd_take);
    end
  end
endmodule

/* design/lpbp_back.sv */
// Back end: tag store, recency ranks and the sequencer for each command.
module lpbp_back #(
  parameter int POOL_ENTRIES = lpbp_pkg::POOL_ENTRIES_DEF,
  parameter int FILE_ID_BITS = lpbp_pkg::FILE_ID_BITS_DEF,
  parameter int PAGE_BITS    = lpbp_pkg::PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [5:0]          pool_limit,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  lpbp_pkg::in_item_t  cmd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpbp_pkg::out_item_t out_data
);
  localparam int SW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_UPDATE, S_WALK, S_OUT
  } state_t;

  state_t state_r;
  logic [POOL_ENTRIES-1:0] valid_r, dirty_r;
  logic [FILE_ID_BITS-1:0] file_r [POOL_ENTRIES];
  logic [PAGE_BITS-1:0]    page_r [POOL_ENTRIES];
  logic [SW-1:0]           age_r  [POOL_ENTRIES];
  logic [CW-1:0]           count_r;
  lpbp_pkg::in_item_t      cmd_r;
  logic [POOL_ENTRIES-1:0] match_r;
  logic [SW-1:0]           walk_r;
  logic                    any_r;
  lpbp_pkg::out_item_t     out_r;
  logic                    out_valid_r;

  logic [FILE_ID_BITS-1:0] key_f;
  logic [PAGE_BITS-1:0]    key_p;
  assign key_f = FILE_ID_BITS'(cmd_data.file_id);
  assign key_p = PAGE_BITS'(cmd_data.page_number);

  // hit slot, victim (oldest valid), lowest free slot after eviction
  logic          hit_c, evict_c;
  logic [SW-1:0] hit_s, vic_s, free_s;
  logic [CW-1:0] lim_c;
  always_comb begin
    hit_c = 1'b0; hit_s = '0; vic_s = '0; free_s = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin hit_c = 1'b1; hit_s = SW'(i); end
    end
    // the oldest entry carries rank count-1
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && age_r[i] == SW'(count_r - 1'b1)) vic_s = SW'(i);
    end
    lim_c = (pool_limit > 6'(POOL_ENTRIES)) ? CW'(POOL_ENTRIES) : CW'(pool_limit);
    evict_c = (count_r >= lim_c) && (count_r != '0);
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i] || (evict_c && SW'(i) == vic_s)) free_s = SW'(i);
    end
  end

  // beats: fetch or single flush, flush-all slot, empty final
  lpbp_pkg::out_item_t look_beat, walk_beat, done_beat;
  logic                more_c;
  always_comb begin
    look_beat = '0;
    look_beat.last = 1'b1;
    if (cmd_r.opcode == lpbp_pkg::OP_FLUSH) begin
      look_beat.hit = hit_c;
      look_beat.slot = 5'(hit_s);
      if (hit_c && dirty_r[hit_s]) begin
        look_beat.writeback_needed = 1'b1;
        look_beat.writeback_file = 8'(file_r[hit_s]);
        look_beat.writeback_page = 32'(page_r[hit_s]);
      end
    end else if (hit_c) begin
      look_beat.hit = 1'b1;
      look_beat.slot = 5'(hit_s);
    end else begin
      look_beat.load_needed = 1'b1;
      look_beat.slot = 5'(free_s);
      if (evict_c && dirty_r[vic_s]) begin
        look_beat.writeback_needed = 1'b1;
        look_beat.writeback_file = 8'(file_r[vic_s]);
        look_beat.writeback_page = 32'(page_r[vic_s]);
      end
    end
    // dirty pages still waiting above the walk position
    more_c = 1'b0;
    for (int i = 0; i < POOL_ENTRIES; i++)
      if (SW'(i) > walk_r && valid_r[i] && dirty_r[i]) more_c = 1'b1;
    walk_beat = '0;
    walk_beat.slot = 5'(walk_r);
    walk_beat.writeback_needed = 1'b1;
    walk_beat.writeback_file = 8'(file_r[walk_r]);
    walk_beat.writeback_page = 32'(page_r[walk_r]);
    walk_beat.last = !more_c;
    done_beat = '0;
    done_beat.last = 1'b1;
  end

  // output register load and hold
  logic out_free, out_set;
  assign out_free = !out_valid_r || !out_stall;
  assign out_set  = ((state_r == S_LOOK || state_r == S_OUT) && out_free) ||
                    (state_r == S_UPDATE && any_r && !out_valid_r &&
                     out_r.writeback_needed && out_r.slot == 5'(walk_r));

  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; dirty_r <= '0; count_r <= '0;
      out_valid_r <= 1'b0; walk_r <= '0; any_r <= 1'b0;
      for (int i = 0; i < POOL_ENTRIES; i++) age_r[i] <= '0;
    end else begin
      out_valid_r <= out_set || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: if (cmd_valid) begin
          cmd_r <= cmd_data;
          // parallel tag compare into a register
          for (int i = 0; i < POOL_ENTRIES; i++)
            match_r[i] <= valid_r[i] && file_r[i] == key_f && page_r[i] == key_p;
          walk_r <= '0; any_r <= 1'b0;
          state_r <= (cmd_data.opcode == lpbp_pkg::OP_FLUSH_ALL) ? S_WALK : S_LOOK;
        end
        S_LOOK: if (out_free) begin
          out_r <= look_beat;
          state_r <= S_IDLE;
          if (cmd_r.opcode == lpbp_pkg::OP_FLUSH) begin
            if (hit_c && dirty_r[hit_s]) dirty_r[hit_s] <= 1'b0;
          end else if (hit_c) begin
            for (int i = 0; i < POOL_ENTRIES; i++)
              if (valid_r[i] && age_r[i] < age_r[hit_s]) age_r[i] <= age_r[i] + 1'b1;
            age_r[hit_s] <= '0;
            if (cmd_r.mark_dirty) dirty_r[hit_s] <= 1'b1;
          end else begin
            // survivors age by one; the new page takes rank 0
            for (int i = 0; i < POOL_ENTRIES; i++) begin
              if (SW'(i) == free_s) age_r[i] <= '0;
              else if (valid_r[i]) age_r[i] <= age_r[i] + 1'b1;
            end
            if (evict_c && vic_s != free_s) valid_r[vic_s] <= 1'b0;
            if (!evict_c) count_r <= count_r + 1'b1;
            valid_r[free_s] <= 1'b1;
            file_r[free_s] <= FILE_ID_BITS'(cmd_r.file_id);
            page_r[free_s] <= PAGE_BITS'(cmd_r.page_number);
            dirty_r[free_s] <= cmd_r.mark_dirty;
          end
        end
        // slots are visited in turn while the output is free; one beat per dirty page
        S_WALK: if (out_free) begin
          if (valid_r[walk_r] && dirty_r[walk_r]) begin
            dirty_r[walk_r] <= 1'b0;
            out_r <= walk_beat;
            any_r <= 1'b1;
          end
          state_r <= S_UPDATE;
        end
        // release the beat just built, then move on or finish
        S_UPDATE: begin
          if (!more_c) begin
            if (!any_r) begin
              state_r <= S_OUT;
            end else state_r <= S_IDLE;
          end else begin
            walk_r <= walk_r + 1'b1;
            state_r <= S_WALK;
          end
        end
        S_OUT: if (out_free) begin
          out_r <= done_beat;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/lru_page_buffer_pool_top.sv */
// LRU page buffer pool tag store. With the back end idle, a fetch or flush
// result passes the queue, the tag compare register and the output register
// after its beat is accepted; the back end takes a new command only once the
// previous result is in the output register. A flush-all walks the slots up
// to the last dirty one with one beat per dirty page, or one empty beat if
// none is dirty. A two-entry command queue in front keeps the input accepting
// while a result waits, until it is full. pool_limit resets to 32; the user
// writes it through the cfg port only while idle, not enforced by the block.
module lru_page_buffer_pool_top #(
  parameter int POOL_ENTRIES = lpbp_pkg::POOL_ENTRIES_DEF,
  parameter int FILE_ID_BITS = lpbp_pkg::FILE_ID_BITS_DEF,
  parameter int PAGE_BITS    = lpbp_pkg::PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpbp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  logic [5:0] limit_r;
  logic cmd_valid, cmd_take;
  lpbp_pkg::in_item_t cmd_data;

  assign cfg_ready = 1'b1;
  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= lpbp_pkg::POOL_LIMIT_RESET;
    else if (cfg_valid) limit_r <= cfg_data;
  end

  lpbp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd_data
  );

  lpbp_back #(
    .POOL_ENTRIES(POOL_ENTRIES), .FILE_ID_BITS(FILE_ID_BITS), .PAGE_BITS(PAGE_BITS)
  ) u_back (
    .clk, .rst_n, .pool_limit(limit_r), .cmd_valid, .cmd_take, .cmd_data,
    .out_valid, .out_stall, .out_data
  );
endmodule

/* design/lpbp_checker.sv */
// Port-level checks
module lpbp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lpbp_pkg::out_item_t out_data
);
  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");
  // a hit never asks for a load
  a_hit_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.load_needed))
    else $error("hit with load");
  // a load beat is a fetch miss, and always last
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.load_needed |-> out_data.last)
    else $error("load beat not last");
  // a beat that is not last carries a write-back
  a_notlast_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.writeback_needed)
    else $error("empty non-final beat");
endmodule

bind lru_page_buffer_pool_top lpbp_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);
